/* hw/rtl/laser_line_column_peaks_macros.svh */
// Assertion macros shared by the laser line column peak finder RTL.
`ifndef LASER_LINE_COLUMN_PEAKS_MACROS_SVH
`define LASER_LINE_COLUMN_PEAKS_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside of reset.
`define LLCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that must hold in the cycle after a trigger, outside of reset.
`define LLCP_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define LLCP_ASSERT(label, prop, msg)
`define LLCP_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

/* hw/rtl/llcp_pkg.sv */
// Package with constants, types and codes of the laser line column peak finder.
package llcp_pkg;

  localparam int MAX_POINTS = 8;
  localparam int MAX_ROWS   = 4096;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int PT_IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int W_W       = 20;
  localparam int GAP_W     = 8;
  localparam int LVL_W     = 8;
  localparam int LIM_W     = 4;
  localparam int ROW_OUT_W = 13;
  localparam int SKIP_W    = ((ROW_W > GAP_W) ? ROW_W : GAP_W) + 1;

  localparam int THR_OFFSET = 197248;
  localparam int U_COEF     = 716;
  localparam int V_COEF     = 825;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_WINDOW = 2'd1,
    MODE_SKIP   = 2'd2
  } llcp_mode_t;

  typedef enum logic {
    PH_SCAN = 1'b0,
    PH_EMIT = 1'b1
  } llcp_phase_t;

  typedef struct packed {
    logic [7:0] u_sample;
    logic [7:0] v_sample;
    logic       last_in_column;
  } llcp_in_t;

  typedef struct packed {
    logic signed [ROW_OUT_W-1:0] point_row;
    logic                        last_point;
  } llcp_out_t;

  // Peak candidate handed from the scanner to the list.
  typedef struct packed {
    logic                  valid;
    logic [ROW_W-1:0]      row;
    logic signed [W_W-1:0] weight;
  } llcp_cand_t;

  // Common control seen by every list cell.
  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      lim;
    logic                  ins_en;
    logic [ROW_W-1:0]      ins_row;
    logic signed [W_W-1:0] ins_weight;
    logic                  take_en;
    logic [PT_IDX_W-1:0]   take_idx;
    logic                  clear;
  } llcp_cell_ctl_t;

  // Data passed from one cell to the next.
  typedef struct packed {
    logic                  cond;
    logic [ROW_W-1:0]      row;
    logic signed [W_W-1:0] weight;
    logic                  sel_valid;
    logic [ROW_W-1:0]      sel_row;
    logic [PT_IDX_W-1:0]   sel_idx;
  } llcp_link_t;

endpackage

/* hw/rtl/llcp_scan.sv */
// Per-pixel weighting, threshold, lookahead window and skip tracking.
`include "laser_line_column_peaks_macros.svh"
module llcp_scan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  llcp_pkg::llcp_in_t     pix,
  input  logic [7:0]             min_level,
  input  logic [7:0]             laser_gap,
  output llcp_pkg::llcp_cand_t   cand
);
  import llcp_pkg::*;

  localparam logic [ROW_W-1:0]  ROW_MAX  = ROW_W'(MAX_ROWS - 1);
  localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(MAX_ROWS - 1);

  logic [ROW_W-1:0]      row_r, row_nxt;
  llcp_mode_t            mode_r, mode_nxt;
  logic [GAP_W-1:0]      wc_r, wc_nxt;
  logic [ROW_W-1:0]      br_r, br_nxt;
  logic signed [W_W-1:0] bw_r, bw_nxt;
  logic [ROW_W-1:0]      skip_r, skip_nxt;

  logic [W_W-1:0]        mag;
  logic signed [W_W-1:0] w;
  logic signed [W_W-1:0] thr;
  llcp_mode_t            mode_eff;
  logic                  step_commit;
  logic                  end_commit;
  logic                  commit;
  logic [SKIP_W-1:0]     skip_sum;

  // Pixel weight and threshold.
  assign mag = W_W'(pix.u_sample) * W_W'(U_COEF) + W_W'(pix.v_sample) * W_W'(V_COEF);
  assign w   = -$signed(mag);
  assign thr = $signed(W_W'({min_level, 8'h00}) - W_W'(THR_OFFSET));

  // Next scan state for one pixel.
  always_comb begin
    mode_eff    = mode_r;
    mode_nxt    = mode_r;
    wc_nxt      = wc_r;
    br_nxt      = br_r;
    bw_nxt      = bw_r;
    skip_nxt    = skip_r;
    step_commit = 1'b0;
    end_commit  = 1'b0;
    skip_sum    = '0;
    if (mode_r == MODE_SKIP && row_r > skip_r) begin
      mode_eff = MODE_SEARCH;
    end
    mode_nxt = mode_eff;
    case (mode_eff)
      MODE_WINDOW: begin
        if (w > bw_r) begin
          bw_nxt = w;
          br_nxt = row_r;
        end
        if (wc_r != '0) begin
          wc_nxt = wc_r - 1'b1;
        end
        if (wc_nxt == '0) begin
          step_commit = 1'b1;
        end
      end
      MODE_SEARCH: begin
        if (w >= thr) begin
          br_nxt   = row_r;
          bw_nxt   = w;
          wc_nxt   = (laser_gap > 8'd1) ? laser_gap - 8'd1 : '0;
          mode_nxt = MODE_WINDOW;
          if (wc_nxt == '0) begin
            step_commit = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // The column end closes a window that is still open.
    if (pix.last_in_column && !step_commit && mode_nxt == MODE_WINDOW) begin
      end_commit = 1'b1;
    end
    commit = step_commit || end_commit;
    if (commit) begin
      skip_sum = SKIP_W'(br_nxt) + SKIP_W'(laser_gap);
      skip_nxt = (skip_sum > SKIP_MAX) ? ROW_MAX : ROW_W'(skip_sum);
      mode_nxt = MODE_SKIP;
      wc_nxt   = '0;
    end
    row_nxt = (row_r < ROW_MAX) ? row_r + 1'b1 : row_r;
    // Column state starts over after the bottom pixel.
    if (pix.last_in_column) begin
      row_nxt  = '0;
      mode_nxt = MODE_SEARCH;
      wc_nxt   = '0;
      skip_nxt = '0;
    end
  end

  assign cand.valid  = commit;
  assign cand.row    = br_nxt;
  assign cand.weight = bw_nxt;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      mode_r <= MODE_SEARCH;
      wc_r   <= '0;
      skip_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      mode_r <= mode_nxt;
      wc_r   <= wc_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Best candidate of the open window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r <= '0;
      bw_r <= '0;
    end else if (accept) begin
      br_r <= pix.last_in_column ? '0 : br_nxt;
      bw_r <= pix.last_in_column ? '0 : bw_nxt;
    end
  end

  `LLCP_ASSERT(a_window_has_rows, mode_r == MODE_WINDOW |-> wc_r != '0, "open window with no rows left")

endmodule

/* hw/rtl/llcp_cell.sv */
// One slot of the strength-ordered peak list, with its share of the row selection.
`include "laser_line_column_peaks_macros.svh"
module llcp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [llcp_pkg::PT_IDX_W-1:0] cell_idx,
  input  llcp_pkg::llcp_cell_ctl_t  ctl,
  input  llcp_pkg::llcp_link_t      link_in,
  output llcp_pkg::llcp_link_t      link_out
);
  import llcp_pkg::*;

  logic [ROW_W-1:0]      row_r;
  logic signed [W_W-1:0] weight_r;
  logic                  taken_r, taken_nxt;
  logic                  valid;
  logic                  in_lim;
  logic                  cond;
  logic                  mine;

  assign valid  = CNT_W'(cell_idx) < ctl.cnt;
  assign in_lim = CNT_W'(cell_idx) < ctl.lim;
  // The newcomer belongs here or above when this slot is empty or weaker.
  assign cond   = !valid || ($signed(ctl.ins_weight) > $signed(weight_r));
  assign mine   = valid && !taken_r;

  // Insertion: shift down from the neighbor, or take the newcomer at its place.
  always_ff @(posedge clk) begin
    if (ctl.ins_en && in_lim) begin
      if (link_in.cond) begin
        row_r    <= link_in.row;
        weight_r <= link_in.weight;
      end else if (cond) begin
        row_r    <= ctl.ins_row;
        weight_r <= ctl.ins_weight;
      end
    end
  end

  // Marks a slot once its row has gone out; the clear at the emit end unmarks it.
  always_comb begin
    taken_nxt = taken_r;
    if (ctl.clear) begin
      taken_nxt = 1'b0;
    end else if (ctl.take_en && ctl.take_idx == cell_idx) begin
      taken_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
    end
  end

  // Running minimum of the rows not yet sent; ties keep the stronger slot.
  always_comb begin
    link_out.cond   = cond;
    link_out.row    = row_r;
    link_out.weight = weight_r;
    if (mine && (!link_in.sel_valid || row_r < link_in.sel_row)) begin
      link_out.sel_valid = 1'b1;
      link_out.sel_row   = row_r;
      link_out.sel_idx   = cell_idx;
    end else begin
      link_out.sel_valid = link_in.sel_valid;
      link_out.sel_row   = link_in.sel_row;
      link_out.sel_idx   = link_in.sel_idx;
    end
  end

  `LLCP_ASSERT(a_taken_is_valid, taken_r |-> valid, "sent mark on an empty slot")

endmodule

/* hw/rtl/laser_line_column_peaks.sv */
// Top level of the laser line column peak finder: config, list chain and output.
//
//   Channel  Dir  Handshake           Payload
//   in_      in   in_valid/in_stall   llcp_in_t: u_sample, v_sample, last_in_column
//   out_     out  out_valid/out_stall llcp_out_t: point_row, last_point
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A pixel is taken every cycle while a column is being scanned; its weight,
// window update and list insertion complete in the same cycle.
// After the bottom pixel the input stalls while the clamped limit (point_limit held
// to one through MAX_POINTS) of items goes out, one a cycle unless out_stall holds.
// Reset is synchronous; it clears control state and loads the register defaults.
// The output register lets the next column start while the final request waits.
`include "laser_line_column_peaks_macros.svh"
module laser_line_column_peaks (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  llcp_pkg::llcp_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output llcp_pkg::llcp_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [llcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [llcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import llcp_pkg::*;

  logic [LVL_W-1:0]    min_level_r;
  logic [GAP_W-1:0]    laser_gap_r;
  logic [LIM_W-1:0]    point_limit_r;

  llcp_phase_t         phase_r, phase_nxt;
  logic [CNT_W-1:0]    kept_r, kept_nxt;
  logic [CNT_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  llcp_out_t           out_data_r;

  logic                in_acc;
  logic                col_end;
  logic                out_load;
  logic                emit_done;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    cnt;
  logic [PT_IDX_W-1:0] lim_idx;
  llcp_cand_t          cand;
  llcp_cell_ctl_t      ctl;
  llcp_link_t          links [MAX_POINTS+1];
  logic [MAX_POINTS-1:0] cond_vec;
  llcp_out_t           out_item;

  // Limit clamped to the list size, at least one.
  function automatic logic [CNT_W-1:0] eff_limit(input logic [LIM_W-1:0] pl);
    logic [CNT_W-1:0] res;
    if (pl == '0) begin
      res = CNT_W'(1);
    end else if (int'(pl) > MAX_POINTS) begin
      res = CNT_W'(MAX_POINTS);
    end else begin
      res = CNT_W'(pl);
    end
    return res;
  endfunction

  assign lim     = eff_limit(point_limit_r);
  assign cnt     = (kept_r < lim) ? kept_r : lim;
  assign lim_idx = PT_IDX_W'(lim - 1'b1);

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r   <= '0;
      laser_gap_r   <= 8'd8;
      point_limit_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_LEVEL:   min_level_r   <= cfg_data;
        CFG_LASER_GAP:   laser_gap_r   <= cfg_data;
        CFG_POINT_LIMIT: point_limit_r <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (phase_r == PH_EMIT);
  assign in_acc   = in_valid && !in_stall;
  assign col_end  = in_acc && in_data.last_in_column;

  llcp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .pix       (in_data),
    .min_level (min_level_r),
    .laser_gap (laser_gap_r),
    .cand      (cand)
  );

  // Cell chain control.
  assign out_load  = (phase_r == PH_EMIT) && (!out_valid_r || !out_stall);
  assign emit_done = out_load && (emit_cnt_r == lim - 1'b1);

  assign ctl.cnt        = cnt;
  assign ctl.lim        = lim;
  assign ctl.ins_en     = in_acc && cand.valid;
  assign ctl.ins_row    = cand.row;
  assign ctl.ins_weight = cand.weight;
  assign ctl.take_en    = out_load && links[MAX_POINTS].sel_valid;
  assign ctl.take_idx   = links[MAX_POINTS].sel_idx;
  assign ctl.clear      = emit_done;

  assign links[0] = '0;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    llcp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (PT_IDX_W'(g)),
      .ctl      (ctl),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
    assign cond_vec[g] = links[g+1].cond;
  end

  // Phase, list fill and emit counter.
  always_comb begin
    phase_nxt    = phase_r;
    kept_nxt     = kept_r;
    emit_cnt_nxt = emit_cnt_r;
    case (phase_r)
      PH_SCAN: begin
        if (in_acc && cand.valid) begin
          if (cond_vec[lim_idx]) begin
            kept_nxt = (cnt < lim) ? cnt + 1'b1 : lim;
          end else begin
            kept_nxt = cnt;
          end
        end
        if (col_end) begin
          phase_nxt    = PH_EMIT;
          emit_cnt_nxt = '0;
        end
      end
      PH_EMIT: begin
        if (out_load) begin
          emit_cnt_nxt = emit_cnt_r + 1'b1;
        end
        if (emit_done) begin
          phase_nxt = PH_SCAN;
          kept_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SCAN;
      kept_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      kept_r     <= kept_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  // Output register: chosen row or the empty marker.
  assign out_item.point_row  = links[MAX_POINTS].sel_valid ?
                               $signed(ROW_OUT_W'(links[MAX_POINTS].sel_row)) : '1;
  assign out_item.last_point = (emit_cnt_r == lim - 1'b1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LLCP_ASSERT_NEXT(a_emit_after_last, col_end, phase_r == PH_EMIT, "no output after column end")
  `LLCP_ASSERT(a_emit_cnt_range, phase_r == PH_EMIT |-> emit_cnt_r < lim, "emit counter past limit")
  `LLCP_ASSERT(a_kept_bound, kept_r <= CNT_W'(MAX_POINTS), "kept count beyond list size")

endmodule
